[rtl/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps

package hsv2rgb_pkg;

	// port widths
	localparam int HUE_BITS     = 10;
	localparam int PORT_BITS    = 8;

	// channel arithmetic
	localparam int CHANNEL_BITS = 8;
	localparam int MAXC         = (1 << CHANNEL_BITS) - 1;
	localparam int SECTOR_DEG   = 60;
	localparam int NUM_SECTORS  = 6;
	localparam int DEN          = SECTOR_DEG * MAXC;
	localparam int DEN_W        = $clog2(DEN + 1);
	localparam int PROD_P_W     = 2 * CHANNEL_BITS;
	localparam int PROD_Q_W     = CHANNEL_BITS + DEN_W;
	localparam int RECIP_W      = CHANNEL_BITS + 2;
	localparam logic [RECIP_W-1:0] RECIP_P =
		RECIP_W'((64'd1 << PROD_P_W) / MAXC);
	localparam logic [RECIP_W-1:0] RECIP_Q =
		RECIP_W'((64'd1 << PROD_Q_W) / DEN);

	// hue decode: hue is offset by whole sectors so it is never negative
	localparam int REM_W            = $clog2(SECTOR_DEG);
	localparam int SEC_W            = 3;
	localparam int HUE_U_W          = HUE_BITS + 1;
	localparam int HUE_OFS_SECTORS  = 9;
	localparam int HUE_OFS          = HUE_OFS_SECTORS * SECTOR_DEG;
	localparam int SEC_ADJ          = (NUM_SECTORS - HUE_OFS_SECTORS % NUM_SECTORS)
		% NUM_SECTORS;
	localparam int HUE_RECIP_SHIFT  = 16;
	localparam int HUE_RECIP_W      = 11;
	localparam logic [HUE_RECIP_W-1:0] HUE_RECIP =
		HUE_RECIP_W'((1 << HUE_RECIP_SHIFT) / SECTOR_DEG + 1);
	localparam int QUOT_W           = 5;

	typedef logic [CHANNEL_BITS-1:0] chan_t;

	typedef enum logic [SEC_W-1:0] {
		SEC_RED_YELLOW   = 3'd0,
		SEC_YELLOW_GREEN = 3'd1,
		SEC_GREEN_CYAN   = 3'd2,
		SEC_CYAN_BLUE    = 3'd3,
		SEC_BLUE_MAGENTA = 3'd4,
		SEC_MAGENTA_RED  = 3'd5
	} sector_t;

endpackage

[rtl/hsv_to_rgb_converter_unit.sv]
`timescale 1ns / 1ps

// HSV to RGB pixel converter. One item (hue in degrees, saturation, value) is
// taken on every clock edge with start high; busy never rises, so start may be
// held high for a continuous pixel stream. Each result appears on red, green
// and blue with done high for exactly one cycle, in the order the items came
// in, having passed through the seven-stage pipeline (hue decode, sector
// remainder, numerators, value multiply, reciprocal estimate, quotient
// correction, channel select). Results must be taken when they appear. Hue
// wraps modulo 360 degrees, saturation zero gives grey and value zero gives
// black; channels are truncated, not rounded.
module hsv_to_rgb_converter_unit (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  logic signed [hsv2rgb_pkg::HUE_BITS-1:0]    hue,
	input  logic        [hsv2rgb_pkg::PORT_BITS-1:0]   saturation,
	input  logic        [hsv2rgb_pkg::PORT_BITS-1:0]   brightness,
	output logic                                       done,
	output logic        [hsv2rgb_pkg::PORT_BITS-1:0]   red,
	output logic        [hsv2rgb_pkg::PORT_BITS-1:0]   green,
	output logic        [hsv2rgb_pkg::PORT_BITS-1:0]   blue
);

	localparam int CB   = hsv2rgb_pkg::CHANNEL_BITS;
	localparam int DW   = hsv2rgb_pkg::DEN_W;
	localparam int PPW  = hsv2rgb_pkg::PROD_P_W;
	localparam int PQW  = hsv2rgb_pkg::PROD_Q_W;
	localparam int RW   = hsv2rgb_pkg::RECIP_W;
	localparam int HUW  = hsv2rgb_pkg::HUE_U_W;
	localparam int HRW  = hsv2rgb_pkg::HUE_RECIP_W;
	localparam int HRS  = hsv2rgb_pkg::HUE_RECIP_SHIFT;
	localparam int QW   = hsv2rgb_pkg::QUOT_W;
	localparam int REMW = hsv2rgb_pkg::REM_W;

	// valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// stage 1: offset hue and sector estimate
	logic [HUW-1:0]               hue_u;
	logic [HUW+HRW-1:0]           hue_prod;
	logic [HUW-1:0]               hue_u_s1;
	logic [QW-1:0]                quot_s1;
	hsv2rgb_pkg::chan_t           s_s1, v_s1;

	// stage 2: remainder and sector
	logic [HUW+QW-1:0]            quot_deg;
	logic [HUW-1:0]               rem_full;
	logic [QW:0]                  sec_sum;
	logic [QW:0]                  sec_mod;
	logic [REMW-1:0]              rem_s2;
	hsv2rgb_pkg::sector_t         sec_s2;
	hsv2rgb_pkg::chan_t           s_s2, v_s2;

	// stage 3: numerators
	logic [CB+REMW-1:0]           sr, st;
	logic [REMW-1:0]              rem_inv;
	logic [CB-1:0]                pn_s3;
	logic [DW-1:0]                qn_s3, tn_s3;
	hsv2rgb_pkg::chan_t           v_s3;
	hsv2rgb_pkg::sector_t         sec_s3;

	// stage 4: value products
	logic [PPW-1:0]               prod_p_s4;
	logic [PQW-1:0]               prod_q_s4, prod_t_s4;
	hsv2rgb_pkg::sector_t         sec_s4;

	// stage 5: quotient estimates, low by at most one
	logic [PPW+RW-1:0]            est_p_full;
	logic [PQW+RW-1:0]            est_q_full, est_t_full;
	hsv2rgb_pkg::chan_t           est_p_s5, est_q_s5, est_t_s5;
	logic [PPW-1:0]               prod_p_s5;
	logic [PQW-1:0]               prod_q_s5, prod_t_s5;
	hsv2rgb_pkg::sector_t         sec_s5;

	// stage 6: corrected quotients
	logic [PPW:0]                 rem_p;
	logic [PQW:0]                 rem_q, rem_t;
	hsv2rgb_pkg::chan_t           p_c, q_c, t_c;
	hsv2rgb_pkg::chan_t           p_s6, q_s6, t_s6, v_s6;
	hsv2rgb_pkg::sector_t         sec_s6;

	// stage 7: channel select
	hsv2rgb_pkg::chan_t           r_sel, g_sel, b_sel;
	hsv2rgb_pkg::chan_t           red_s7, green_s7, blue_s7;

	// value travels alongside for the select
	hsv2rgb_pkg::chan_t           v_s4, v_s5;

	assign busy = 1'b0;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// stage 1
	always_comb begin
		hue_u    = {hue[hsv2rgb_pkg::HUE_BITS-1], hue} + HUW'(hsv2rgb_pkg::HUE_OFS);
		hue_prod = HUW'(hue_u) * (HUW+HRW)'(hsv2rgb_pkg::HUE_RECIP);
	end

	always_ff @(posedge clk) begin
		hue_u_s1 <= hue_u;
		quot_s1  <= hue_prod[HRS+QW-1:HRS];
		s_s1     <= CB'(saturation);
		v_s1     <= CB'(brightness);
	end

	// stage 2: sector is floor modulo six, undoing the offset
	always_comb begin
		quot_deg = (HUW+QW)'(quot_s1) * (HUW+QW)'(hsv2rgb_pkg::SECTOR_DEG);
		rem_full = hue_u_s1 - quot_deg[HUW-1:0];
		sec_sum  = (QW+1)'(quot_s1) + (QW+1)'(hsv2rgb_pkg::SEC_ADJ);
		sec_mod  = sec_sum;
		if (sec_mod >= (QW+1)'(3 * hsv2rgb_pkg::NUM_SECTORS)) begin
			sec_mod = sec_mod - (QW+1)'(3 * hsv2rgb_pkg::NUM_SECTORS);
		end else if (sec_mod >= (QW+1)'(2 * hsv2rgb_pkg::NUM_SECTORS)) begin
			sec_mod = sec_mod - (QW+1)'(2 * hsv2rgb_pkg::NUM_SECTORS);
		end else if (sec_mod >= (QW+1)'(hsv2rgb_pkg::NUM_SECTORS)) begin
			sec_mod = sec_mod - (QW+1)'(hsv2rgb_pkg::NUM_SECTORS);
		end
	end

	always_ff @(posedge clk) begin
		rem_s2 <= rem_full[REMW-1:0];
		sec_s2 <= hsv2rgb_pkg::sector_t'(sec_mod[hsv2rgb_pkg::SEC_W-1:0]);
		s_s2   <= s_s1;
		v_s2   <= v_s1;
	end

	// stage 3
	always_comb begin
		rem_inv = REMW'(hsv2rgb_pkg::SECTOR_DEG) - rem_s2;
		sr      = (CB+REMW)'(s_s2) * (CB+REMW)'(rem_s2);
		st      = (CB+REMW)'(s_s2) * (CB+REMW)'(rem_inv);
	end

	always_ff @(posedge clk) begin
		pn_s3  <= CB'(hsv2rgb_pkg::MAXC) - s_s2;
		qn_s3  <= DW'(hsv2rgb_pkg::DEN) - DW'(sr);
		tn_s3  <= DW'(hsv2rgb_pkg::DEN) - DW'(st);
		v_s3   <= v_s2;
		sec_s3 <= sec_s2;
	end

	// stage 4
	always_ff @(posedge clk) begin
		prod_p_s4 <= PPW'(v_s3) * PPW'(pn_s3);
		prod_q_s4 <= PQW'(v_s3) * PQW'(qn_s3);
		prod_t_s4 <= PQW'(v_s3) * PQW'(tn_s3);
		v_s4      <= v_s3;
		sec_s4    <= sec_s3;
	end

	// stage 5: multiply by truncated reciprocal
	always_comb begin
		est_p_full = (PPW+RW)'(prod_p_s4) * (PPW+RW)'(hsv2rgb_pkg::RECIP_P);
		est_q_full = (PQW+RW)'(prod_q_s4) * (PQW+RW)'(hsv2rgb_pkg::RECIP_Q);
		est_t_full = (PQW+RW)'(prod_t_s4) * (PQW+RW)'(hsv2rgb_pkg::RECIP_Q);
	end

	always_ff @(posedge clk) begin
		est_p_s5  <= est_p_full[PPW+CB-1:PPW];
		est_q_s5  <= est_q_full[PQW+CB-1:PQW];
		est_t_s5  <= est_t_full[PQW+CB-1:PQW];
		prod_p_s5 <= prod_p_s4;
		prod_q_s5 <= prod_q_s4;
		prod_t_s5 <= prod_t_s4;
		v_s5      <= v_s4;
		sec_s5    <= sec_s4;
	end

	// stage 6: bump the estimate when the remainder is still a full divisor
	always_comb begin
		rem_p = (PPW+1)'(prod_p_s5)
			- (PPW+1)'(est_p_s5) * (PPW+1)'(hsv2rgb_pkg::MAXC);
		rem_q = (PQW+1)'(prod_q_s5)
			- (PQW+1)'(est_q_s5) * (PQW+1)'(hsv2rgb_pkg::DEN);
		rem_t = (PQW+1)'(prod_t_s5)
			- (PQW+1)'(est_t_s5) * (PQW+1)'(hsv2rgb_pkg::DEN);
		p_c = est_p_s5 + CB'(rem_p >= (PPW+1)'(hsv2rgb_pkg::MAXC));
		q_c = est_q_s5 + CB'(rem_q >= (PQW+1)'(hsv2rgb_pkg::DEN));
		t_c = est_t_s5 + CB'(rem_t >= (PQW+1)'(hsv2rgb_pkg::DEN));
	end

	always_ff @(posedge clk) begin
		p_s6   <= p_c;
		q_s6   <= q_c;
		t_s6   <= t_c;
		v_s6   <= v_s5;
		sec_s6 <= sec_s5;
	end

	// stage 7: grey and black fall out of the formulas, p = q = t = v there
	always_comb begin
		case (sec_s6)
			hsv2rgb_pkg::SEC_RED_YELLOW: begin
				r_sel = v_s6; g_sel = t_s6; b_sel = p_s6;
			end
			hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
				r_sel = q_s6; g_sel = v_s6; b_sel = p_s6;
			end
			hsv2rgb_pkg::SEC_GREEN_CYAN: begin
				r_sel = p_s6; g_sel = v_s6; b_sel = t_s6;
			end
			hsv2rgb_pkg::SEC_CYAN_BLUE: begin
				r_sel = p_s6; g_sel = q_s6; b_sel = v_s6;
			end
			hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
				r_sel = t_s6; g_sel = p_s6; b_sel = v_s6;
			end
			default: begin
				r_sel = v_s6; g_sel = p_s6; b_sel = q_s6;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		red_s7   <= r_sel;
		green_s7 <= g_sel;
		blue_s7  <= b_sel;
	end

	assign done  = valid_s7;
	assign red   = hsv2rgb_pkg::PORT_BITS'(red_s7);
	assign green = hsv2rgb_pkg::PORT_BITS'(green_s7);
	assign blue  = hsv2rgb_pkg::PORT_BITS'(blue_s7);

endmodule
